/* hw/rtl/first_fit_block_allocator_macros.svh */
// Assertion macros shared by the allocator RTL.
// No dependencies; included by the controller and datapath modules.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define FFBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication, checked out of reset
`define FFBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

/* hw/rtl/ffba_pkg.sv */
// Shared types, codes and default sizes for the first-fit block allocator.
// No dependencies; used by ffba_ctrl, ffba_dp and the top level.
`timescale 1ns / 1ps
package ffba_pkg;

	localparam int ARENA_BYTES_DEF  = 65536;
	localparam int MAX_BLOCKS_DEF   = 1024;
	localparam int HEADER_BYTES_DEF = 16;
	localparam int ALIGN_BYTES      = 8;

	localparam logic [1:0] OP_ALLOC  = 2'd0;
	localparam logic [1:0] OP_FREE   = 2'd1;
	localparam logic [1:0] OP_RESIZE = 2'd2;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_NO_SPACE   = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND  = 2'd2;
	localparam logic [1:0] ST_TABLE_FULL = 2'd3;

	// index register updates
	localparam logic [2:0] IDX_HOLD  = 3'd0;
	localparam logic [2:0] IDX_ZERO  = 3'd1;
	localparam logic [2:0] IDX_INC   = 3'd2;
	localparam logic [2:0] IDX_DEC   = 3'd3;
	localparam logic [2:0] IDX_TOTAL = 3'd4;
	localparam logic [2:0] IDX_SLOT1 = 3'd5;

	// table read address select
	localparam logic [2:0] RD_IDX   = 3'd0;
	localparam logic [2:0] RD_IDXM1 = 3'd1;
	localparam logic [2:0] RD_IDXP1 = 3'd2;
	localparam logic [2:0] RD_SLOT1 = 3'd3;
	localparam logic [2:0] RD_OLD   = 3'd4;

	// table write select
	localparam logic [2:0] WR_COPY  = 3'd0;
	localparam logic [2:0] WR_TAIL  = 3'd1;
	localparam logic [2:0] WR_HEAD  = 3'd2;
	localparam logic [2:0] WR_TAKE  = 3'd3;
	localparam logic [2:0] WR_CLR   = 3'd4;
	localparam logic [2:0] WR_MERGE = 3'd5;
	localparam logic [2:0] WR_CLROLD = 3'd6;

	// response select
	localparam logic [1:0] RES_STATUS = 2'd0;
	localparam logic [1:0] RES_SLOT   = 2'd1;
	localparam logic [1:0] RES_ADDR   = 2'd2;
	localparam logic [1:0] RES_MOVED  = 2'd3;

	typedef struct packed {
		logic [1:0]  operation;
		logic [16:0] request_size;
		logic [15:0] block_address;
	} req_t;

	typedef struct packed {
		logic [15:0] result_address;
		logic [1:0]  status;
		logic        moved;
		logic [15:0] old_address;
		logic [16:0] copy_length;
	} rsp_t;

	typedef struct packed {
		logic [15:0] start;
		logic [16:0] bytes;
		logic        used;
	} ent_t;

	typedef struct packed {
		logic       load_req;
		logic [2:0] idx_op;
		logic [2:0] rd_sel;
		logic       wr_en;
		logic [2:0] wr_sel;
		logic       hit_cap;
		logic       mode_fit;
		logic       total_inc;
		logic       total_dec;
		logic       old_save;
		logic       old_adj;
		logic       res_load;
		logic [1:0] res_sel;
		logic [1:0] res_status;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       addr_zero;
		logic       idx_end;
		logic       hit;
		logic       need_split;
		logic       table_full;
		logic       keep;
		logic       has_next;
		logic       merge_ok;
		logic       up_more;
		logic       dn_more;
	} sts_t;

endpackage

/* hw/rtl/ffba_ctrl.sv */
// Sequencer for the allocator: walks scan, shift, split, merge and relocate steps.
// Depends on ffba_pkg and first_fit_block_allocator_macros.svh.
`timescale 1ns / 1ps
`include "first_fit_block_allocator_macros.svh"
module ffba_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	input  ffba_pkg::sts_t  sts,
	output ffba_pkg::cmd_t  cmd
);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_DISP   = 5'd1;
	localparam logic [4:0] S_SCAN   = 5'd2;
	localparam logic [4:0] S_CHECK  = 5'd3;
	localparam logic [4:0] S_HIT    = 5'd4;
	localparam logic [4:0] S_UP     = 5'd5;
	localparam logic [4:0] S_UP_WR  = 5'd6;
	localparam logic [4:0] S_HEAD   = 5'd7;
	localparam logic [4:0] S_POST   = 5'd8;
	localparam logic [4:0] S_OLD_RD = 5'd9;
	localparam logic [4:0] S_OLD_WR = 5'd10;
	localparam logic [4:0] S_NEXT   = 5'd11;
	localparam logic [4:0] S_RELOC  = 5'd12;
	localparam logic [4:0] S_DN     = 5'd13;
	localparam logic [4:0] S_DN_WR  = 5'd14;
	localparam logic [4:0] S_DONE   = 5'd15;

	logic [4:0] state_q, state_d;
	logic       fit_q, fit_d;
	logic       reloc_q, reloc_d;
	logic [1:0] sel_q, sel_d;
	logic [1:0] st_q, st_d;
	logic       rsp_valid_q;
	logic       out_free;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_d = state_q;
		fit_d   = fit_q;
		reloc_d = reloc_q;
		sel_d   = sel_q;
		st_d    = st_q;
		cmd     = '0;
		cmd.mode_fit = fit_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load_req = 1'b1;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				cmd.idx_op = ffba_pkg::IDX_ZERO;
				reloc_d = 1'b0;
				state_d = S_SCAN;
				if (sts.op == ffba_pkg::OP_ALLOC ||
						(sts.op == ffba_pkg::OP_RESIZE && sts.addr_zero)) begin
					fit_d = 1'b1;
				end else if (sts.op == ffba_pkg::OP_FREE || sts.op == ffba_pkg::OP_RESIZE) begin
					fit_d = 1'b0;
					if (sts.op == ffba_pkg::OP_FREE && sts.addr_zero) begin
						sel_d = ffba_pkg::RES_STATUS;
						st_d = ffba_pkg::ST_OK;
						state_d = S_DONE;
					end
				end else begin
					sel_d = ffba_pkg::RES_STATUS;
					st_d = ffba_pkg::ST_OK;
					state_d = S_DONE;
				end
			end
			S_SCAN: begin
				if (sts.idx_end) begin
					sel_d = ffba_pkg::RES_STATUS;
					st_d = fit_q ? ffba_pkg::ST_NO_SPACE : ffba_pkg::ST_NOT_FOUND;
					state_d = S_DONE;
				end else begin
					cmd.rd_sel = ffba_pkg::RD_IDX;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.hit) begin
					cmd.hit_cap = 1'b1;
					state_d = S_HIT;
				end else begin
					cmd.idx_op = ffba_pkg::IDX_INC;
					state_d = S_SCAN;
				end
			end
			S_HIT: begin
				if (fit_q) begin
					if (sts.need_split) begin
						if (sts.table_full) begin
							sel_d = ffba_pkg::RES_STATUS;
							st_d = ffba_pkg::ST_TABLE_FULL;
							state_d = S_DONE;
						end else begin
							cmd.idx_op = ffba_pkg::IDX_TOTAL;
							state_d = S_UP;
						end
					end else begin
						cmd.wr_en = 1'b1;
						cmd.wr_sel = ffba_pkg::WR_TAKE;
						state_d = S_POST;
					end
				end else if (sts.op == ffba_pkg::OP_FREE) begin
					cmd.wr_en = 1'b1;
					cmd.wr_sel = ffba_pkg::WR_CLR;
					sel_d = ffba_pkg::RES_STATUS;
					st_d = ffba_pkg::ST_OK;
					state_d = S_DONE;
				end else if (sts.keep) begin
					sel_d = ffba_pkg::RES_ADDR;
					state_d = S_DONE;
				end else if (sts.has_next) begin
					cmd.rd_sel = ffba_pkg::RD_SLOT1;
					state_d = S_NEXT;
				end else begin
					state_d = S_RELOC;
				end
			end
			S_UP: begin
				if (sts.up_more) begin
					cmd.rd_sel = ffba_pkg::RD_IDXM1;
					state_d = S_UP_WR;
				end else begin
					cmd.wr_en = 1'b1;
					cmd.wr_sel = ffba_pkg::WR_TAIL;
					state_d = S_HEAD;
				end
			end
			S_UP_WR: begin
				cmd.wr_en = 1'b1;
				cmd.wr_sel = ffba_pkg::WR_COPY;
				cmd.idx_op = ffba_pkg::IDX_DEC;
				state_d = S_UP;
			end
			S_HEAD: begin
				cmd.wr_en = 1'b1;
				cmd.wr_sel = ffba_pkg::WR_HEAD;
				cmd.total_inc = 1'b1;
				state_d = S_POST;
			end
			S_POST: begin
				if (reloc_q) begin
					cmd.old_adj = 1'b1;
					state_d = S_OLD_RD;
				end else begin
					sel_d = ffba_pkg::RES_SLOT;
					state_d = S_DONE;
				end
			end
			S_OLD_RD: begin
				cmd.rd_sel = ffba_pkg::RD_OLD;
				state_d = S_OLD_WR;
			end
			S_OLD_WR: begin
				cmd.wr_en = 1'b1;
				cmd.wr_sel = ffba_pkg::WR_CLROLD;
				sel_d = ffba_pkg::RES_MOVED;
				state_d = S_DONE;
			end
			S_NEXT: begin
				if (sts.merge_ok) begin
					cmd.wr_en = 1'b1;
					cmd.wr_sel = ffba_pkg::WR_MERGE;
					cmd.idx_op = ffba_pkg::IDX_SLOT1;
					state_d = S_DN;
				end else begin
					state_d = S_RELOC;
				end
			end
			S_RELOC: begin
				cmd.old_save = 1'b1;
				cmd.idx_op = ffba_pkg::IDX_ZERO;
				fit_d = 1'b1;
				reloc_d = 1'b1;
				state_d = S_SCAN;
			end
			S_DN: begin
				if (sts.dn_more) begin
					cmd.rd_sel = ffba_pkg::RD_IDXP1;
					state_d = S_DN_WR;
				end else begin
					cmd.total_dec = 1'b1;
					sel_d = ffba_pkg::RES_ADDR;
					state_d = S_DONE;
				end
			end
			S_DN_WR: begin
				cmd.wr_en = 1'b1;
				cmd.wr_sel = ffba_pkg::WR_COPY;
				cmd.idx_op = ffba_pkg::IDX_INC;
				state_d = S_DN;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.res_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		cmd.res_sel = sel_q;
		cmd.res_status = st_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fit_q <= 1'b0;
			reloc_q <= 1'b0;
			sel_q <= ffba_pkg::RES_STATUS;
			st_q <= ffba_pkg::ST_OK;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fit_q <= fit_d;
			reloc_q <= reloc_d;
			sel_q <= sel_d;
			st_q <= st_d;
			if (cmd.res_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	`FFBA_ASSERT_NXT(a_accept_leaves_idle, clk, arst_n, req_valid && req_ready, state_q != S_IDLE, "accepted transaction did not start")
	`FFBA_ASSERT_IMP(a_idle_no_write, clk, arst_n, state_q == S_IDLE, !cmd.wr_en, "table write while idle")
	`FFBA_ASSERT_IMP(a_load_when_free, clk, arst_n, cmd.res_load, out_free, "response overwritten before taken")

endmodule

/* hw/rtl/ffba_dp.sv */
// Datapath: block table memory, index and count registers, fit/match logic, response register.
// Depends on ffba_pkg and first_fit_block_allocator_macros.svh.
`timescale 1ns / 1ps
`include "first_fit_block_allocator_macros.svh"
module ffba_dp #(
	parameter int ARENA_BYTES  = ffba_pkg::ARENA_BYTES_DEF,
	parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF,
	parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  ffba_pkg::req_t req,
	input  ffba_pkg::cmd_t cmd,
	output ffba_pkg::sts_t sts,
	output ffba_pkg::rsp_t rsp
);

	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int CW = IW + 1;
	localparam logic [17:0]   HDR    = 18'(HEADER_BYTES);
	localparam logic [17:0]   ALN    = 18'(ffba_pkg::ALIGN_BYTES - 1);
	localparam logic [16:0]   BYTES0 = 17'(ARENA_BYTES - HEADER_BYTES);
	localparam logic [CW-1:0] MAXC   = CW'(MAX_BLOCKS);

	ffba_pkg::ent_t mem [MAX_BLOCKS];
	ffba_pkg::ent_t rd_q, rdata, ent_q, wd;
	ffba_pkg::req_t req_q;
	ffba_pkg::rsp_t rsp_q;
	logic [CW-1:0]  idx_q, total_q, slot1, old_q;
	logic [IW-1:0]  slot_q, ra, wa;
	logic [16:0]    old_len_q;
	logic           init0_q, rz_q, we;
	logic [17:0]    size, tail_start, tail_bytes, sum;
	logic [15:0]    pay;

	// aligned request size
	assign size  = ({1'b0, req_q.request_size} + ALN) & ~ALN;
	assign slot1 = {1'b0, slot_q} + CW'(1);
	// entry 0 reads as the reset block until first written
	assign rdata = rz_q ? '{start: 16'd0, bytes: BYTES0, used: 1'b0} : rd_q;
	assign tail_start = 18'(ent_q.start) + HDR + size;
	assign tail_bytes = 18'(ent_q.bytes) - size - HDR;
	assign sum = 18'(ent_q.bytes) + HDR + 18'(rdata.bytes);
	assign pay = 16'(18'(ent_q.start) + HDR);
	// an old block pushed past the last table slot is left alone
	assign we = cmd.wr_en && (cmd.wr_sel != ffba_pkg::WR_CLROLD || old_q < MAXC);

	always_comb begin
		unique case (cmd.rd_sel)
			ffba_pkg::RD_IDXM1: ra = IW'(idx_q - CW'(1));
			ffba_pkg::RD_IDXP1: ra = IW'(idx_q + CW'(1));
			ffba_pkg::RD_SLOT1: ra = slot1[IW-1:0];
			ffba_pkg::RD_OLD:   ra = old_q[IW-1:0];
			default:            ra = idx_q[IW-1:0];
		endcase
	end

	always_comb begin
		wa = slot_q;
		wd = ent_q;
		unique case (cmd.wr_sel)
			ffba_pkg::WR_COPY: begin
				wa = idx_q[IW-1:0];
				wd = rdata;
			end
			ffba_pkg::WR_TAIL: begin
				wa = slot1[IW-1:0];
				wd = '{start: tail_start[15:0], bytes: tail_bytes[16:0], used: 1'b0};
			end
			ffba_pkg::WR_HEAD: wd = '{start: ent_q.start, bytes: size[16:0], used: 1'b1};
			ffba_pkg::WR_TAKE: wd = '{start: ent_q.start, bytes: ent_q.bytes, used: 1'b1};
			ffba_pkg::WR_CLR:  wd = '{start: ent_q.start, bytes: ent_q.bytes, used: 1'b0};
			ffba_pkg::WR_MERGE: wd = '{start: ent_q.start, bytes: sum[16:0], used: 1'b1};
			ffba_pkg::WR_CLROLD: begin
				wa = old_q[IW-1:0];
				wd = '{start: rdata.start, bytes: rdata.bytes, used: 1'b0};
			end
			default: wd = ent_q;
		endcase
	end

	always_comb begin
		sts.op         = req_q.operation;
		sts.addr_zero  = (req_q.block_address == 16'd0);
		sts.idx_end    = (idx_q >= total_q);
		sts.hit        = cmd.mode_fit ? (!rdata.used && 18'(rdata.bytes) >= size)
		                 : (rdata.used && (17'(rdata.start) + 17'(HEADER_BYTES))
		                    == {1'b0, req_q.block_address});
		sts.need_split = (18'(ent_q.bytes) - size) > HDR;
		sts.table_full = (total_q >= MAXC);
		sts.keep       = (ent_q.bytes >= req_q.request_size);
		sts.has_next   = (slot1 < total_q);
		sts.merge_ok   = !rdata.used && (sum >= 18'(req_q.request_size));
		sts.up_more    = (idx_q > slot1);
		sts.dn_more    = ((idx_q + CW'(1)) < total_q);
	end

	// table memory, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[ra];
		rz_q <= (ra == '0) && !init0_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			total_q <= CW'(1);
			init0_q <= 1'b0;
		end else begin
			if (we && wa == '0) begin
				init0_q <= 1'b1;
			end
			if (cmd.total_inc) begin
				total_q <= total_q + CW'(1);
			end else if (cmd.total_dec) begin
				total_q <= total_q - CW'(1);
			end
			unique case (cmd.idx_op)
				ffba_pkg::IDX_ZERO:  idx_q <= '0;
				ffba_pkg::IDX_INC:   idx_q <= idx_q + CW'(1);
				ffba_pkg::IDX_DEC:   idx_q <= idx_q - CW'(1);
				ffba_pkg::IDX_TOTAL: idx_q <= total_q;
				ffba_pkg::IDX_SLOT1: idx_q <= slot1;
				default:             idx_q <= idx_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= req;
		end
		if (cmd.hit_cap) begin
			ent_q <= rdata;
			slot_q <= idx_q[IW-1:0];
		end
		if (cmd.old_save) begin
			old_q <= {1'b0, slot_q};
			old_len_q <= ent_q.bytes;
		end else if (cmd.old_adj && {1'b0, slot_q} < old_q) begin
			old_q <= old_q + CW'(1);
		end
		if (cmd.res_load) begin
			unique case (cmd.res_sel)
				ffba_pkg::RES_SLOT: rsp_q <= '{result_address: pay, status: ffba_pkg::ST_OK,
					moved: 1'b0, old_address: 16'd0, copy_length: 17'd0};
				ffba_pkg::RES_ADDR: rsp_q <= '{result_address: req_q.block_address,
					status: ffba_pkg::ST_OK, moved: 1'b0, old_address: 16'd0,
					copy_length: 17'd0};
				ffba_pkg::RES_MOVED: rsp_q <= '{result_address: pay, status: ffba_pkg::ST_OK,
					moved: 1'b1, old_address: req_q.block_address, copy_length: old_len_q};
				default: rsp_q <= '{result_address: 16'd0, status: cmd.res_status,
					moved: 1'b0, old_address: 16'd0, copy_length: 17'd0};
			endcase
		end
	end

	assign rsp = rsp_q;

	`FFBA_ASSERT_IMP(a_total_range, clk, arst_n, 1'b1, total_q >= CW'(1) && total_q <= MAXC, "block count out of range")
	`FFBA_ASSERT_IMP(a_grow_room, clk, arst_n, cmd.total_inc, total_q < MAXC, "split with a full table")
	`FFBA_ASSERT_IMP(a_shrink_room, clk, arst_n, cmd.total_dec, total_q > CW'(1), "merge with a single block")

endmodule

/* hw/rtl/first_fit_block_allocator.sv */
// Top level of the first-fit block allocator: sequencer plus table datapath.
// Depends on ffba_pkg, ffba_ctrl and ffba_dp.
`timescale 1ns / 1ps
//
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------------------------
//  request | req_valid / req_ready  | req: operation, request_size, block_address
//  reply   | rsp_valid / rsp_ready  | rsp: result_address, status, moved,
//          |                        |      old_address, copy_length
//
// One transaction at a time. Each table entry scanned takes a read and then a compare,
// and each entry moved when a split or merge shifts the table takes a read and then a
// write, on a table memory that does one read and one write per cycle.
// Reset (arst_n low) leaves one free block spanning the arena; no clearing pass.
// A finished reply sits in the output register while the next request is taken;
// a stalled reply holds the sequencer only at its final step.
module first_fit_block_allocator #(
	parameter int ARENA_BYTES  = ffba_pkg::ARENA_BYTES_DEF,
	parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF,
	parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  ffba_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output ffba_pkg::rsp_t rsp
);

	ffba_pkg::cmd_t cmd;
	ffba_pkg::sts_t sts;

	// sequencer: owns the handshakes and the step order
	ffba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: block table, counters and the reply register
	ffba_dp #(
		.ARENA_BYTES  (ARENA_BYTES),
		.MAX_BLOCKS   (MAX_BLOCKS),
		.HEADER_BYTES (HEADER_BYTES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

/* tb/tb_first_fit_block_allocator.sv */
// Self-checking testbench for first_fit_block_allocator: directed and random requests.
// Depends on ffba_pkg and the allocator RTL; holds its own model of the block table.
`timescale 1ns / 1ps
module tb_first_fit_block_allocator;

	localparam int ARENA  = 65536;
	localparam int NSLOTS = 1024;
	localparam int HDR    = 16;
	localparam int RANDOM_ITEMS = 500;
	localparam int FILL_CAP     = 40;
	localparam int TAIL_CYCLES  = 100;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	// covers ~580 requests, stalls on top
	localparam longint CYCLE_LIMIT = 64'd10_000_000;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	ffba_pkg::req_t req;
	logic rsp_valid;
	logic rsp_ready;
	ffba_pkg::rsp_t rsp;

	first_fit_block_allocator uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	// ---------------------------------------------------------------
	// Mirror of the block table: address-ordered headers, sizes, marks
	// ---------------------------------------------------------------
	logic [15:0] hdr_start [NSLOTS];
	int          pay_bytes [NSLOTS];
	bit          in_use    [NSLOTS];
	int          live_blocks;

	ffba_pkg::req_t request_queue[$];  // transactions waiting for the driver
	ffba_pkg::rsp_t pending_replies[$]; // predicted replies, oldest first
	int   error_count;
	int   sent_count;
	longint cycle_count;
	logic req_fire;

	function automatic int align8(int n);
		return (n + 7) & ~7;
	endfunction

	function automatic int find_owner(int addr);
		for (int i = 0; i < live_blocks; i++)
			if (in_use[i] && int'(hdr_start[i]) + HDR == addr)
				return i;
		return live_blocks;
	endfunction

	// first fit over the table; splits only when the leftover beats one header
	function automatic logic [1:0] carve_block(int sz, output int slot);
		int i;
		slot = 0;
		for (i = 0; i < live_blocks; i++)
			if (!in_use[i] && pay_bytes[i] >= sz)
				break;
		if (i >= live_blocks)
			return ffba_pkg::ST_NO_SPACE;
		if (pay_bytes[i] - sz > HDR) begin
			if (live_blocks >= NSLOTS)
				return ffba_pkg::ST_TABLE_FULL;
			for (int j = live_blocks; j > i + 1; j--) begin
				hdr_start[j] = hdr_start[j-1];
				pay_bytes[j] = pay_bytes[j-1];
				in_use[j]    = in_use[j-1];
			end
			hdr_start[i+1] = 16'(int'(hdr_start[i]) + HDR + sz);
			pay_bytes[i+1] = pay_bytes[i] - sz - HDR;
			in_use[i+1]    = 0;
			pay_bytes[i]   = sz;
			live_blocks++;
		end
		in_use[i] = 1;
		slot = i;
		return ffba_pkg::ST_OK;
	endfunction

	// runs one request through the mirror, queues it and its predicted reply
	function automatic ffba_pkg::rsp_t issue(logic [1:0] op, int sz, int addr);
		ffba_pkg::rsp_t r;
		ffba_pkg::req_t q;
		int slot, i, old_len;
		r = '0;
		q.operation = op;
		q.request_size = sz[16:0];
		q.block_address = addr[15:0];
		if (op == ffba_pkg::OP_ALLOC || (op == ffba_pkg::OP_RESIZE && addr == 0)) begin
			r.status = carve_block(align8(sz), slot);
			if (r.status == ffba_pkg::ST_OK)
				r.result_address = 16'(int'(hdr_start[slot]) + HDR);
		end else if (op == ffba_pkg::OP_FREE) begin
			if (addr != 0) begin
				i = find_owner(addr);
				if (i < live_blocks)
					in_use[i] = 0;
				else
					r.status = ffba_pkg::ST_NOT_FOUND;
			end
		end else if (op == ffba_pkg::OP_RESIZE) begin
			i = find_owner(addr);
			if (i >= live_blocks) begin
				r.status = ffba_pkg::ST_NOT_FOUND;
			end else if (pay_bytes[i] >= sz) begin
				r.result_address = addr[15:0];
			end else if (i + 1 < live_blocks && !in_use[i+1]
					&& pay_bytes[i] + HDR + pay_bytes[i+1] >= sz) begin
				// absorb free successor, header included
				pay_bytes[i] = pay_bytes[i] + HDR + pay_bytes[i+1];
				for (int j = i + 1; j + 1 < live_blocks; j++) begin
					hdr_start[j] = hdr_start[j+1];
					pay_bytes[j] = pay_bytes[j+1];
					in_use[j]    = in_use[j+1];
				end
				live_blocks--;
				r.result_address = addr[15:0];
			end else begin
				old_len = pay_bytes[i];
				r.status = carve_block(align8(sz), slot);
				if (r.status == ffba_pkg::ST_OK) begin
					if (slot < i)
						i++;
					r.result_address = 16'(int'(hdr_start[slot]) + HDR);
					if (i < NSLOTS)
						in_use[i] = 0;
					r.moved = 1'b1;
					r.old_address = addr[15:0];
					r.copy_length = old_len[16:0];
				end
			end
		end
		request_queue.push_back(q);
		pending_replies.push_back(r);
		return r;
	endfunction

	// payload address of a random in-use block, 0 when none
	function automatic int any_live();
		int hits[$];
		for (int i = 0; i < live_blocks; i++)
			if (in_use[i])
				hits.push_back(int'(hdr_start[i]) + HDR);
		if (hits.size() == 0)
			return 0;
		return hits[$urandom_range(0, hits.size() - 1)];
	endfunction

	function automatic int pick_size();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(0, ARENA);
		return $urandom_range(0, 300);
	endfunction

	// ---------------------------------------------------------------
	// Clock, reset
	// ---------------------------------------------------------------
	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// idle mode rotates with progress: none, sender gaps, receiver stalls, both
	function automatic int gap_pct();
		case ((sent_count / 50) % 4)
			1: return 80;
			3: return 35;
			default: return 0;
		endcase
	endfunction

	function automatic int stall_pct();
		case ((sent_count / 50) % 4)
			2: return 80;
			3: return 35;
			default: return 0;
		endcase
	endfunction

	// ---------------------------------------------------------------
	// Driver: request side and reply back-pressure, driven at negedge
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_fire <= 0;
			sent_count <= 0;
		end else begin
			req_fire <= req_valid && req_ready;
			if (req_valid && req_ready)
				sent_count <= sent_count + 1;
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			// hold the payload until the transaction has been taken
			if (!req_valid || req_fire) begin
				if (request_queue.size() > 0 && $urandom_range(0, 99) >= gap_pct()) begin
					req <= request_queue.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
			rsp_ready <= ($urandom_range(0, 99) >= stall_pct());
		end
	end

	// ---------------------------------------------------------------
	// Monitor: compare each reply with the oldest prediction
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		ffba_pkg::rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_replies.size() == 0) begin
				$error("unexpected reply transaction: %p", rsp);
				error_count++;
			end else begin
				want = pending_replies.pop_front();
				if (rsp.result_address !== want.result_address) begin
					$error("result_address exp %0d got %0d", want.result_address,
						rsp.result_address);
					error_count++;
				end
				if (rsp.status !== want.status) begin
					$error("status exp %0d got %0d", want.status, rsp.status);
					error_count++;
				end
				if (rsp.moved !== want.moved) begin
					$error("moved exp %0d got %0d", want.moved, rsp.moved);
					error_count++;
				end
				if (rsp.old_address !== want.old_address) begin
					$error("old_address exp %0d got %0d", want.old_address, rsp.old_address);
					error_count++;
				end
				if (rsp.copy_length !== want.copy_length) begin
					$error("copy_length exp %0d got %0d", want.copy_length, rsp.copy_length);
					error_count++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus and end of test
	// ---------------------------------------------------------------
	initial begin
		ffba_pkg::rsp_t r;
		int a_zero, a_one, a_mid, n, fulls, pick;
		arst_n = 0;
		req_valid = 0;
		req = '0;
		rsp_ready = 0;
		error_count = 0;
		cycle_count = 0;
		for (int i = 0; i < NSLOTS; i++) begin
			hdr_start[i] = '0;
			pay_bytes[i] = 0;
			in_use[i] = 0;
		end
		pay_bytes[0] = ARENA - HDR;
		live_blocks = 1;

		// directed: zero size, rounding, overflow, frees, every resize path
		r = issue(ffba_pkg::OP_ALLOC, 0, 0);          a_zero = r.result_address;
		r = issue(ffba_pkg::OP_ALLOC, 1, 0);          a_one = r.result_address;
		r = issue(ffba_pkg::OP_ALLOC, 65536, 0);      // bigger than the arena
		r = issue(ffba_pkg::OP_ALLOC, 100, 0);        a_mid = r.result_address;
		r = issue(ffba_pkg::OP_FREE, 0, 0);           // null free
		r = issue(ffba_pkg::OP_FREE, 0, 16'hFFFF);    // unknown address
		r = issue(ffba_pkg::OP_FREE, 0, a_one);
		r = issue(ffba_pkg::OP_FREE, 0, a_one);       // already free
		r = issue(ffba_pkg::OP_RESIZE, 40, 0);        // null resize acts as allocate
		r = issue(ffba_pkg::OP_RESIZE, 8, 16'h5A5A);  // unknown address
		r = issue(ffba_pkg::OP_RESIZE, 50, a_mid);    // fits in place
		r = issue(ffba_pkg::OP_ALLOC, 0, 0);
		r = issue(ffba_pkg::OP_FREE, 0, r.result_address);
		r = issue(ffba_pkg::OP_RESIZE, 8, a_zero);    // absorbs free neighbor
		r = issue(ffba_pkg::OP_RESIZE, 5000, a_mid);  // relocates
		r = issue(ffba_pkg::OP_RESIZE, 65536, a_zero); // relocation fails
		r = issue(OP_UNUSED, 17'h1FFFF, 16'hFFFF);
		r = issue(ffba_pkg::OP_ALLOC, 65520 - 16, 0);
		r = issue(ffba_pkg::OP_FREE, 0, r.result_address);

		// random mix, mostly well-formed against live blocks
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45)
				r = issue(ffba_pkg::OP_ALLOC, pick_size(), 0);
			else if (pick < 75)
				r = issue(ffba_pkg::OP_FREE, 0, ($urandom_range(0, 9) == 0) ?
					$urandom_range(0, 65535) : any_live());
			else if (pick < 95)
				r = issue(ffba_pkg::OP_RESIZE, pick_size(), ($urandom_range(0, 9) == 0) ?
					$urandom_range(0, 65535) : any_live());
			else
				r = issue(OP_UNUSED, $urandom_range(0, 131071), $urandom_range(0, 65535));
		end

		// burst of tiny allocations, stops early after six table-full replies
		fulls = 0;
		for (n = 0; n < FILL_CAP && fulls < 6; n++) begin
			r = issue(ffba_pkg::OP_ALLOC, $urandom_range(0, 9), 0);
			if (r.status == ffba_pkg::ST_TABLE_FULL)
				fulls++;
		end
		for (n = 0; n < 20; n++)
			r = issue(($urandom_range(0, 1) == 0) ? ffba_pkg::OP_FREE : ffba_pkg::OP_RESIZE,
				$urandom_range(0, 64), any_live());

		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1;

		while (request_queue.size() > 0 || req_valid || pending_replies.size() > 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
